@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock, quiet while in reset
`define TSE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tse assertion failed");

// same with a caller message
`define TSE_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

@@ sv/tse_pkg.sv @@
`default_nettype none
package tse_pkg;

	// parser phase codes
	localparam logic [4:0] PH_REC_TYPE     = 5'd0;
	localparam logic [4:0] PH_REC_V1       = 5'd1;
	localparam logic [4:0] PH_REC_V2       = 5'd2;
	localparam logic [4:0] PH_REC_L1       = 5'd3;
	localparam logic [4:0] PH_REC_L2       = 5'd4;
	localparam logic [4:0] PH_HS_TYPE      = 5'd5;
	localparam logic [4:0] PH_HS_L1        = 5'd6;
	localparam logic [4:0] PH_HS_L2        = 5'd7;
	localparam logic [4:0] PH_HS_L3        = 5'd8;
	localparam logic [4:0] PH_SKIP_RANDOM  = 5'd9;
	localparam logic [4:0] PH_SESS_LEN     = 5'd10;
	localparam logic [4:0] PH_SKIP_SESSION = 5'd11;
	localparam logic [4:0] PH_CIPH_HI      = 5'd12;
	localparam logic [4:0] PH_CIPH_LO      = 5'd13;
	localparam logic [4:0] PH_SKIP_CIPHERS = 5'd14;
	localparam logic [4:0] PH_COMP_LEN     = 5'd15;
	localparam logic [4:0] PH_SKIP_COMP    = 5'd16;
	localparam logic [4:0] PH_EXTS_HI      = 5'd17;
	localparam logic [4:0] PH_EXTS_LO      = 5'd18;
	localparam logic [4:0] PH_EXT_T1       = 5'd19;
	localparam logic [4:0] PH_EXT_T2       = 5'd20;
	localparam logic [4:0] PH_EXT_L1       = 5'd21;
	localparam logic [4:0] PH_EXT_L2       = 5'd22;
	localparam logic [4:0] PH_SKIP_EXT     = 5'd23;
	localparam logic [4:0] PH_LIST_HI      = 5'd24;
	localparam logic [4:0] PH_LIST_LO      = 5'd25;
	localparam logic [4:0] PH_NAME_TYPE    = 5'd26;
	localparam logic [4:0] PH_NAME_L1      = 5'd27;
	localparam logic [4:0] PH_NAME_L2      = 5'd28;
	localparam logic [4:0] PH_NAME_BYTES   = 5'd29;
	localparam logic [4:0] PH_SKIP_NAME    = 5'd30;
	localparam logic [4:0] PH_IDLE         = 5'd31;

	localparam logic [16:0] POS_MAX      = 17'h1FFFF;
	localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
	localparam logic [16:0] MIN_RECORD   = 17'd9;
	localparam logic [17:0] RANDOM_SKIP  = 18'd34;

	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// one output item
	typedef struct packed {
		logic       kind;
		logic [7:0] name_byte;
		logic       found;
		logic       run_end;
	} result_t;

endpackage
`default_nettype wire

@@ sv/tse_parser.sv @@
`default_nettype none
module tse_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic [7:0]     data_byte,
	input  wire logic           last_byte,
	input  wire logic [7:0]     max_name_len,
	output      logic [1:0]     res_cnt,
	output      tse_pkg::result_t res0,
	output      tse_pkg::result_t res1
);
	import tse_pkg::*;

	typedef struct packed {
		logic [4:0]  ph;
		logic [16:0] pos;
		logic [16:0] rec_end;
		logic [16:0] hs_end;
		logic [16:0] exts_end;
		logic [16:0] body_end;
		logic [16:0] nlist_end;
		logic [16:0] fe;
		logic [15:0] acc;
		logic [7:0]  emitted;
		logic        is_sni;
		logic        is_host;
		logic        complete;
		logic        rejected;
	} pst_t;

	typedef struct packed {
		logic [4:0]  ph;
		logic [16:0] fe;
		logic        rej;
	} settle_t;

	pst_t st_q, st_d;

	// leave one finished skip at position n
	function automatic settle_t settle_step(settle_t s, logic [16:0] n, logic [16:0] hs_end,
			logic [16:0] exts_end, logic [16:0] nlist_end, logic [16:0] body_end);
		settle_t r;
		logic [17:0] n18;
		r = s;
		n18 = {1'b0, n};
		if (n >= s.fe) begin
			unique case (s.ph)
				PH_SKIP_RANDOM: r.ph = PH_SESS_LEN;
				PH_SKIP_SESSION: begin
					if (n18 + 18'd2 > {1'b0, hs_end}) begin
						r.ph = PH_IDLE; r.rej = 1'b1;
					end else r.ph = PH_CIPH_HI;
				end
				PH_SKIP_CIPHERS: begin
					if (n18 + 18'd1 > {1'b0, hs_end}) begin
						r.ph = PH_IDLE; r.rej = 1'b1;
					end else r.ph = PH_COMP_LEN;
				end
				PH_SKIP_COMP: begin
					if (n18 + 18'd2 > {1'b0, hs_end}) begin
						r.ph = PH_IDLE; r.rej = 1'b1;
					end else r.ph = PH_EXTS_HI;
				end
				PH_SKIP_EXT: r.ph = (n18 + 18'd4 <= {1'b0, exts_end}) ? PH_EXT_T1 : PH_IDLE;
				PH_SKIP_NAME: begin
					if (n18 + 18'd3 <= {1'b0, nlist_end}) r.ph = PH_NAME_TYPE;
					else begin
						r.fe = body_end; r.ph = PH_SKIP_EXT;
					end
				end
				PH_NAME_BYTES: r.ph = PH_IDLE;
				default: r = s;
			endcase
		end
		return r;
	endfunction

	logic [16:0] n;
	logic [17:0] n18, e;
	logic [15:0] w;
	logic [23:0] v;
	logic [24:0] hend;
	logic        emit, fnd;
	settle_t     s0, s1, s2;

	// next parser state for the byte at hand
	always_comb begin
		st_d = st_q;
		n    = (st_q.pos == POS_MAX) ? st_q.pos : st_q.pos + 17'd1;
		n18  = {1'b0, n};
		w    = {st_q.acc[7:0], data_byte};
		v    = {st_q.acc, data_byte};
		e    = n18 + {2'b0, w};
		hend = {8'b0, n} + {1'b0, v};
		emit = 1'b0;
		unique case (st_q.ph)
			PH_REC_TYPE: begin
				if (data_byte != REC_HANDSHAKE) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else st_d.ph = PH_REC_V1;
			end
			PH_REC_V1: st_d.ph = PH_REC_V2;
			PH_REC_V2: st_d.ph = PH_REC_L1;
			PH_REC_L1: begin
				st_d.acc = {8'b0, data_byte}; st_d.ph = PH_REC_L2;
			end
			PH_REC_L2: begin
				st_d.rec_end = 17'd5 + {1'b0, w}; st_d.ph = PH_HS_TYPE;
			end
			PH_HS_TYPE: begin
				if (data_byte != HS_CLIENT_HELLO) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else st_d.ph = PH_HS_L1;
			end
			PH_HS_L1: begin
				st_d.acc = {8'b0, data_byte}; st_d.ph = PH_HS_L2;
			end
			PH_HS_L2: begin
				st_d.acc = w; st_d.ph = PH_HS_L3;
			end
			PH_HS_L3: begin
				st_d.acc = v[15:0];
				if (hend > {8'b0, st_q.rec_end}
						|| {7'b0, n18 + RANDOM_SKIP + 18'd1} > hend) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.hs_end = hend[16:0];
					st_d.fe     = 17'(n18 + RANDOM_SKIP);
					st_d.ph     = PH_SKIP_RANDOM;
				end
			end
			PH_SESS_LEN, PH_COMP_LEN: begin
				if (n18 + {10'b0, data_byte} > {1'b0, st_q.hs_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.fe = 17'(n18 + {10'b0, data_byte});
					st_d.ph = (st_q.ph == PH_SESS_LEN) ? PH_SKIP_SESSION : PH_SKIP_COMP;
				end
			end
			PH_CIPH_HI, PH_EXTS_HI, PH_EXT_T1, PH_EXT_L1, PH_LIST_HI, PH_NAME_L1: begin
				st_d.acc = {8'b0, data_byte};
				st_d.ph  = st_q.ph + 5'd1;
			end
			PH_CIPH_LO: begin
				if (e > {1'b0, st_q.hs_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.fe = e[16:0]; st_d.ph = PH_SKIP_CIPHERS;
				end
			end
			PH_EXTS_LO: begin
				if (e > {1'b0, st_q.hs_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.exts_end = e[16:0];
					st_d.ph = (n18 + 18'd4 <= e) ? PH_EXT_T1 : PH_IDLE;
				end
			end
			PH_EXT_T2: begin
				st_d.is_sni = (w == 16'd0); st_d.ph = PH_EXT_L1;
			end
			PH_EXT_L2: begin
				if (e > {1'b0, st_q.exts_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.body_end = e[16:0];
					if (!st_q.is_sni) begin
						st_d.fe = e[16:0]; st_d.ph = PH_SKIP_EXT;
					end else if (n18 + 18'd2 > e) begin
						st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
					end else st_d.ph = PH_LIST_HI;
				end
			end
			PH_LIST_LO: begin
				if (e > {1'b0, st_q.body_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else begin
					st_d.nlist_end = e[16:0];
					if (n18 + 18'd3 <= e) st_d.ph = PH_NAME_TYPE;
					else begin
						st_d.fe = st_q.body_end; st_d.ph = PH_SKIP_EXT;
					end
				end
			end
			PH_NAME_TYPE: begin
				st_d.is_host = (data_byte == 8'd0); st_d.ph = PH_NAME_L1;
			end
			PH_NAME_L2: begin
				if (e > {1'b0, st_q.nlist_end}) begin
					st_d.ph = PH_IDLE; st_d.rejected = 1'b1;
				end else if (st_q.is_host) begin
					st_d.complete = 1'b1; st_d.emitted = 8'd0;
					st_d.fe = e[16:0]; st_d.ph = PH_NAME_BYTES;
				end else begin
					st_d.fe = e[16:0]; st_d.ph = PH_SKIP_NAME;
				end
			end
			PH_NAME_BYTES: begin
				emit = (st_q.emitted < max_name_len);
				if (st_q.emitted != 8'hFF) st_d.emitted = st_q.emitted + 8'd1;
			end
			default: st_d.ph = st_q.ph;
		endcase

		// at most two skips can end on one byte
		s0 = '{ph: st_d.ph, fe: st_d.fe, rej: st_d.rejected};
		s1 = settle_step(s0, n, st_d.hs_end, st_d.exts_end, st_d.nlist_end, st_d.body_end);
		s2 = settle_step(s1, n, st_d.hs_end, st_d.exts_end, st_d.nlist_end, st_d.body_end);
		st_d.ph = s2.ph; st_d.fe = s2.fe; st_d.rejected = s2.rej;
		st_d.pos = n;

		fnd = st_d.complete && !st_d.rejected && n >= st_d.rec_end && n >= MIN_RECORD;
		if (last_byte) begin
			st_d    = '0;
			st_d.ph = PH_REC_TYPE;
		end
	end

	// results of this byte, name byte first
	always_comb begin
		res0 = '{kind: KIND_NAME, name_byte: data_byte, found: 1'b0, run_end: !last_byte};
		res1 = '{kind: KIND_VERDICT, name_byte: 8'd0, found: fnd, run_end: 1'b1};
		if (!emit) res0 = res1;
		res_cnt = {1'b0, emit} + {1'b0, last_byte};
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{ph: PH_REC_TYPE, default: '0};
		end else if (en) begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/tls_sni_extractor.sv @@
// TLS ClientHello server name extractor. Takes a TCP payload one byte per item on the
// slave stream (tlast on the final byte) and emits the first host_name of the server_name
// extension as name byte items, cut to max_name_len bytes, then one verdict item on the
// final byte; every length is checked against its enclosing structure and an overrun
// rejects the buffer. Each byte is parsed in the cycle it is accepted and its results land
// in a two-entry output buffer, so one byte is taken per cycle unless the output stalls;
// a byte that yields both a name byte and the verdict holds the input while the buffer drains.
// max_name_len resets to 255; the user must write it only while the block is idle (not enforced).
`default_nettype none
module tls_sni_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,   // max_name_len
	input  wire logic       s_axis_tvalid,
	output      logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  wire logic       s_axis_tlast,  // last_byte
	output      logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output      logic [15:0] m_axis_tdata, // [7:0] name_byte, [8] found, zero above
	output      logic       m_axis_tuser,  // result_kind
	output      logic       m_axis_tlast   // run_end
);
	import tse_pkg::*;

	logic [7:0] max_name_len_q;
	logic       acc, pop;
	logic [1:0] res_cnt;
	result_t    res0, res1;
	result_t    out_q, hold_q;
	logic       out_vld_q, hold_vld_q;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_name_len_q <= 8'hFF;
		else if (cfg_wr_en) max_name_len_q <= cfg_wr_data;
	end

	assign pop           = out_vld_q && m_axis_tready;
	assign s_axis_tready = !hold_vld_q && (!out_vld_q || m_axis_tready);
	assign acc           = s_axis_tvalid && s_axis_tready;

	tse_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (acc),
		.data_byte    (s_axis_tdata),
		.last_byte    (s_axis_tlast),
		.max_name_len (max_name_len_q),
		.res_cnt      (res_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	// output buffer valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else if (acc) begin
			out_vld_q  <= (res_cnt != 2'd0);
			hold_vld_q <= (res_cnt == 2'd2);
		end else if (pop) begin
			out_vld_q  <= hold_vld_q;
			hold_vld_q <= 1'b0;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_q  <= res0;
			hold_q <= res1;
		end else if (pop) begin
			out_q <= hold_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'b0, out_q.found, out_q.name_byte};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.run_end;

endmodule
`default_nettype wire

@@ sv/tse_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module tse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);
	import tse_pkg::*;

	// stalled output item holds
	`TSE_ASSERT(a_out_hold, clk, arst_n,
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	// verdict closes the run and carries no name byte
	`TSE_ASSERT_MSG(a_verdict_shape, clk, arst_n,
		m_axis_tvalid && m_axis_tuser == KIND_VERDICT |->
		m_axis_tlast && m_axis_tdata[7:0] == 8'd0, "verdict item malformed")
	// name byte never claims found
	`TSE_ASSERT(a_name_no_found, clk, arst_n,
		m_axis_tvalid && m_axis_tuser == KIND_NAME |-> !m_axis_tdata[8])
	// name byte of the final input byte blocks the input and is followed at once by its verdict
	`TSE_ASSERT_MSG(a_verdict_follows, clk, arst_n,
		m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_NAME && !m_axis_tlast |->
		!s_axis_tready ##1 (m_axis_tvalid && m_axis_tuser == KIND_VERDICT),
		"verdict missing after name byte")

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ test/tb_tls_sni_extractor.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_tls_sni_extractor;
	import tse_pkg::*;

	// one expected output item
	typedef struct packed {
		logic       kind;
		logic [7:0] name_byte;
		logic       found;
		logic       run_end;
	} sni_result_t;

	// predicts the parser output and holds the outstanding results
	class sni_scoreboard;
		int          name_limit;
		logic [4:0]  phase;
		int          pos, rec_end, hs_end, exts_end, ext_end, nlist_end, fld_end;
		int          acc;
		int          emitted;
		bit          is_sni, is_host, got_name, rejected;
		sni_result_t pending[$];
		int          errors;

		function new();
			name_limit = 255;
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_REC_TYPE;
			pos = 0; rec_end = 0; hs_end = 0; exts_end = 0;
			ext_end = 0; nlist_end = 0; fld_end = 0;
			acc = 0; emitted = 0;
			is_sni = 1'b0; is_host = 1'b0; got_name = 1'b0; rejected = 1'b0;
		endfunction

		function void drop();
			phase = PH_IDLE;
			rejected = 1'b1;
		endfunction

		function void skip_to(int n, int len, int limit, logic [4:0] ph);
			if (n + len > limit) drop();
			else begin
				fld_end = n + len;
				phase = ph;
			end
		endfunction

		function void ext_next(int n);
			phase = (n + 4 <= exts_end) ? PH_EXT_T1 : PH_IDLE;
		endfunction

		function void entry_next(int n);
			if (n + 3 <= nlist_end) phase = PH_NAME_TYPE;
			else begin
				fld_end = ext_end;
				phase = PH_SKIP_EXT;
			end
		endfunction

		function void add(bit k, logic [7:0] nb, bit f, bit e);
			sni_result_t r;
			r.kind = k; r.name_byte = nb; r.found = f; r.run_end = e;
			pending.push_back(r);
		endfunction

		// one accepted payload byte
		function void note_byte(logic [7:0] b, bit last);
			int n, w, v;
			bit busy;
			n = (pos < int'(POS_MAX)) ? pos + 1 : int'(POS_MAX);
			w = int'({acc[7:0], b});
			case (phase)
				PH_REC_TYPE: if (b != REC_HANDSHAKE) drop(); else phase = PH_REC_V1;
				PH_REC_V1: phase = PH_REC_V2;
				PH_REC_V2: phase = PH_REC_L1;
				PH_REC_L1: begin acc = int'(b); phase = PH_REC_L2; end
				PH_REC_L2: begin rec_end = 5 + w; phase = PH_HS_TYPE; end
				PH_HS_TYPE: if (b != HS_CLIENT_HELLO) drop(); else phase = PH_HS_L1;
				PH_HS_L1: begin acc = int'(b); phase = PH_HS_L2; end
				PH_HS_L2: begin acc = int'({acc[7:0], b}); phase = PH_HS_L3; end
				PH_HS_L3: begin
					v = int'({acc[15:0], b});
					acc = v;
					if (n + v > rec_end || n + 35 > n + v) drop();
					else begin
						hs_end = n + v;
						fld_end = n + 34;
						phase = PH_SKIP_RANDOM;
					end
				end
				PH_SESS_LEN: skip_to(n, int'(b), hs_end, PH_SKIP_SESSION);
				PH_CIPH_HI: begin acc = int'(b); phase = PH_CIPH_LO; end
				PH_CIPH_LO: skip_to(n, w, hs_end, PH_SKIP_CIPHERS);
				PH_COMP_LEN: skip_to(n, int'(b), hs_end, PH_SKIP_COMP);
				PH_EXTS_HI: begin acc = int'(b); phase = PH_EXTS_LO; end
				PH_EXTS_LO:
					if (n + w > hs_end) drop();
					else begin exts_end = n + w; ext_next(n); end
				PH_EXT_T1: begin acc = int'(b); phase = PH_EXT_T2; end
				PH_EXT_T2: begin is_sni = (w == 0); phase = PH_EXT_L1; end
				PH_EXT_L1: begin acc = int'(b); phase = PH_EXT_L2; end
				PH_EXT_L2:
					if (n + w > exts_end) drop();
					else begin
						ext_end = n + w;
						if (!is_sni) begin
							fld_end = n + w;
							phase = PH_SKIP_EXT;
						end else if (n + 2 > ext_end) drop();
						else phase = PH_LIST_HI;
					end
				PH_LIST_HI: begin acc = int'(b); phase = PH_LIST_LO; end
				PH_LIST_LO:
					if (n + w > ext_end) drop();
					else begin nlist_end = n + w; entry_next(n); end
				PH_NAME_TYPE: begin is_host = (b == 8'd0); phase = PH_NAME_L1; end
				PH_NAME_L1: begin acc = int'(b); phase = PH_NAME_L2; end
				PH_NAME_L2:
					if (n + w > nlist_end) drop();
					else begin
						if (is_host) begin
							got_name = 1'b1;
							emitted = 0;
							phase = PH_NAME_BYTES;
						end else phase = PH_SKIP_NAME;
						fld_end = n + w;
					end
				PH_NAME_BYTES: begin
					if (emitted < name_limit) add(KIND_NAME, b, 1'b0, !last);
					if (emitted < 255) emitted++;
				end
				default: ;
			endcase
			// leave every skip that ends here
			busy = 1'b1;
			while (busy) begin
				busy = (phase == PH_SKIP_RANDOM || phase == PH_SKIP_SESSION ||
					phase == PH_SKIP_CIPHERS || phase == PH_SKIP_COMP ||
					phase == PH_SKIP_EXT || phase == PH_SKIP_NAME ||
					phase == PH_NAME_BYTES) && n >= fld_end;
				if (busy) begin
					case (phase)
						PH_SKIP_RANDOM: phase = PH_SESS_LEN;
						PH_SKIP_SESSION: if (n + 2 > hs_end) drop(); else phase = PH_CIPH_HI;
						PH_SKIP_CIPHERS: if (n + 1 > hs_end) drop(); else phase = PH_COMP_LEN;
						PH_SKIP_COMP: if (n + 2 > hs_end) drop(); else phase = PH_EXTS_HI;
						PH_SKIP_EXT: ext_next(n);
						PH_SKIP_NAME: entry_next(n);
						default: phase = PH_IDLE;
					endcase
				end
			end
			pos = n;
			if (last) begin
				add(KIND_VERDICT, 8'd0,
					got_name && !rejected && n >= rec_end && n >= int'(MIN_RECORD), 1'b1);
				clear();
			end
		endfunction

		// one accepted output item
		function void check(sni_result_t got);
			sni_result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result kind=%0d byte=%0h", got.kind, got.name_byte);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind) begin
				$error("result_kind exp %0d got %0d", exp.kind, got.kind); errors++;
			end
			if (got.name_byte !== exp.name_byte) begin
				$error("name_byte exp %0h got %0h", exp.name_byte, got.name_byte); errors++;
			end
			if (got.found !== exp.found) begin
				$error("found exp %0d got %0d", exp.found, got.found); errors++;
			end
			if (got.run_end !== exp.run_end) begin
				$error("run_end exp %0d got %0d", exp.run_end, got.run_end); errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;  // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;  // last_byte
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [15:0] m_axis_tdata;      // [7:0] name_byte, [8] found
	wire         m_axis_tuser;      // result_kind
	wire         m_axis_tlast;      // run_end

	sni_scoreboard sb = new();
	int   hold_cycles = 0;
	bit   quiet_sink = 1'b0;
	byte  buf_bytes[$];

	tls_sni_extractor i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one byte, waiting for the handshake; valid stays up unless a gap follows
	task automatic put_byte(logic [7:0] b, bit last, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_byte(b, last);
		@(negedge clk);
	endtask

	task automatic send_buffer(bit gaps);
		for (int i = 0; i < buf_bytes.size(); i++)
			put_byte(buf_bytes[i], i == buf_bytes.size() - 1, gaps);
		buf_bytes.delete();
	endtask

	// stop offering items and wait for every expected result
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(logic [7:0] v);
		wait_drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.name_limit = int'(v);
	endtask

	function automatic void push16(int v);
		buf_bytes.push_back(v[15:8]);
		buf_bytes.push_back(v[7:0]);
	endfunction

	// well-formed client hello, optionally damaged
	task automatic build_hello(int host_len, bit other_ext, bit other_entry,
			int flaw, int trunc);
		byte body[$];
		byte ext[$];
		int  sid, nc, i;
		sid = $urandom_range(0, 3);
		nc = $urandom_range(1, 3);
		// extensions
		if (other_ext) begin
			ext.push_back(8'h00); ext.push_back(8'h0a); ext.push_back(8'h00);
			ext.push_back(8'h02);
			ext.push_back(8'($urandom)); ext.push_back(8'($urandom));
		end
		ext.push_back(8'h00); ext.push_back(8'h00);
		i = 2 + (other_entry ? 4 : 0) + 3 + host_len;
		ext.push_back(8'(i >> 8)); ext.push_back(8'(i));
		i -= 2;
		ext.push_back(8'(i >> 8)); ext.push_back(8'(i));
		if (other_entry) begin
			ext.push_back(8'h01); ext.push_back(8'h00); ext.push_back(8'h01);
			ext.push_back(8'($urandom));
		end
		ext.push_back(8'h00); ext.push_back(8'(host_len >> 8)); ext.push_back(8'(host_len));
		for (i = 0; i < host_len; i++) ext.push_back(8'($urandom_range(8'h61, 8'h7a)));
		// handshake body
		body.push_back(8'h03); body.push_back(8'h03);
		for (i = 0; i < 32; i++) body.push_back(8'($urandom));
		body.push_back(8'(sid));
		for (i = 0; i < sid; i++) body.push_back(8'($urandom));
		body.push_back(8'h00); body.push_back(8'(2 * nc));
		for (i = 0; i < 2 * nc; i++) body.push_back(8'($urandom));
		body.push_back(8'h01); body.push_back(8'h00);
		body.push_back(8'(ext.size() >> 8)); body.push_back(8'(ext.size()));
		foreach (ext[k]) body.push_back(ext[k]);
		// damage the host name length byte, the first cipher suite byte or a header byte
		if (flaw == 1) body[body.size() - host_len - 1] = 8'hff;
		if (flaw == 2) body[36 + sid + 1] = 8'hff;
		buf_bytes.push_back(flaw == 3 ? 8'h17 : REC_HANDSHAKE);
		buf_bytes.push_back(8'h03); buf_bytes.push_back(8'h01);
		push16(body.size() + 4);
		buf_bytes.push_back(flaw == 4 ? 8'h02 : HS_CLIENT_HELLO);
		buf_bytes.push_back(8'h00); push16(body.size());
		foreach (body[k]) buf_bytes.push_back(body[k]);
		if (flaw == 5) for (i = 0; i < 3; i++) buf_bytes.push_back(8'($urandom));
		while (trunc > 0 && buf_bytes.size() > 1) begin
			void'(buf_bytes.pop_back());
			trunc--;
		end
	endtask

	// receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (quiet_sink)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 9) < 7);
	end

	always @(posedge clk) begin
		sni_result_t r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.kind = m_axis_tuser;
			r.name_byte = m_axis_tdata[7:0];
			r.found = m_axis_tdata[8];
			r.run_end = m_axis_tlast;
			sb.check(r);
		end
	end

	initial begin
		int limits[5];
		limits = '{255, 0, 1, 5, 255};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: bare bytes and extremes
		put_byte(8'h00, 1'b1, 1'b0);
		put_byte(8'hff, 1'b1, 1'b0);
		buf_bytes = '{8'h16, 8'h03, 8'h01, 8'h00, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00};
		send_buffer(1'b0);
		quiet_sink = 1'b1;
		build_hello(6, 1'b1, 1'b1, 0, 0); send_buffer(1'b0);
		quiet_sink = 1'b0;
		build_hello(3, 1'b0, 1'b0, 4, 0); send_buffer(1'b0);

		// several settings of the name limit
		foreach (limits[p]) begin
			int flaw;
			set_limit(8'(limits[p]));
			flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
			if (p == 0) hold_cycles = 400;
			build_hello(($urandom_range(0, 9) == 0) ? $urandom_range(200, 300)
				: $urandom_range(0, 12), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)),
				flaw, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0);
			send_buffer(1'b1);
			// random noise buffer
			if ($urandom_range(0, 2) == 0) begin
				for (int i = $urandom_range(1, 12); i > 0; i--)
					buf_bytes.push_back(8'($urandom));
				send_buffer(1'b1);
			end
			if (p == 2) wait_drain();
		end
		wait_drain();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tls_sni_extractor regression: pass");
		else
			$display("tls_sni_extractor regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("tls_sni_extractor regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
